FILE: hw/rtl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants of the length-prefixed deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

   localparam int unsigned DATA_W   = 8;
   localparam int unsigned ID_W     = 16;
   localparam int unsigned LEN_W    = 32;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned HCOUNT_W = 3;
   localparam int unsigned PHASE_W  = 2;

   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'd65536;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_BODY  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

   // parser phases
   localparam logic [PHASE_W-1:0] PH_LEN    = 2'd0;
   localparam logic [PHASE_W-1:0] PH_ID     = 2'd1;
   localparam logic [PHASE_W-1:0] PH_BODY   = 2'd2;
   localparam logic [PHASE_W-1:0] PH_CLOSED = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   message_id;
      logic [LEN_W-1:0]  body_length;
      logic [DATA_W-1:0] body_byte;
      logic              first_of_body;
      logic              last_of_body;
   } lpd_result_type;

endpackage

FILE: hw/rtl/length_prefixed_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_deframer
// Cut-through deframer for a byte stream with length and id headers.
// An accepted byte waits in the input register; its result is then registered on rsp.
// Throughput: one byte per cycle while rsp_stall holds no result, set by the input and result registers.
// Reset: synchronous; parser back to length header, limit back to 65536.
// After an oversize length the stream stays closed until reset.
// ----------------------------------------------------------------------------
module length_prefixed_deframer #(
   parameter int unsigned LENGTH_BYTES = 4,
   parameter int unsigned ID_BYTES     = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [lpd_pkg::DATA_W-1:0]  req_data_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lpd_pkg::KIND_W-1:0]  rsp_result_kind,
   output logic [lpd_pkg::ID_W-1:0]    rsp_message_id,
   output logic [lpd_pkg::LEN_W-1:0]   rsp_body_length,
   output logic [lpd_pkg::DATA_W-1:0]  rsp_body_byte,
   output logic                        rsp_first_of_body,
   output logic                        rsp_last_of_body,
   input  logic                        csr_wr_en,
   input  logic [lpd_pkg::LEN_W-1:0]   csr_wr_data
);
   import lpd_pkg::*;

   logic [LEN_W-1:0]  max_len_ff;
   logic              in_valid_ff, in_valid_in;
   logic [DATA_W-1:0] in_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   lpd_result_type    rsp_ff;

   logic              out_free;
   logic              advance;
   logic              req_take;
   logic              res_valid;
   lpd_result_type    res;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign advance     = in_valid_ff && out_free;
   assign req_stall   = in_valid_ff && !out_free;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance ? res_valid : (rsp_valid_ff && rsp_stall);

   lpd_parse #(
      .LENGTH_BYTES (LENGTH_BYTES),
      .ID_BYTES     (ID_BYTES)
   ) u_parse (
      .clock           (clock),
      .reset           (reset),
      .take            (advance),
      .data_byte       (in_data_ff),
      .max_body_length (max_len_ff),
      .result_valid    (res_valid),
      .result          (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= MAX_LEN_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data_byte;
      end
      if (advance && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_ff.kind;
   assign rsp_message_id    = rsp_ff.message_id;
   assign rsp_body_length   = rsp_ff.body_length;
   assign rsp_body_byte     = rsp_ff.body_byte;
   assign rsp_first_of_body = rsp_ff.first_of_body;
   assign rsp_last_of_body  = rsp_ff.last_of_body;

   // error result carries no id and no marks
   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == KIND_ERROR |->
         rsp_ff.message_id == '0 && !rsp_ff.first_of_body && !rsp_ff.last_of_body)
      else $error("error item has stray fields");

   // empty message is a last mark with zero length
   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == KIND_EMPTY |->
         rsp_ff.last_of_body && !rsp_ff.first_of_body && rsp_ff.body_length == '0)
      else $error("empty item has bad fields");

   // a held result is not overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("stalled result changed");

   // an item waiting in the input register is never lost
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("waiting item dropped");

endmodule

FILE: hw/rtl/lpd_parse.sv
// ----------------------------------------------------------------------------
// lpd_parse
// Frame header parser and body tagger; updates its state once per item.
// ----------------------------------------------------------------------------
module lpd_parse #(
   parameter int unsigned LENGTH_BYTES = 4,
   parameter int unsigned ID_BYTES     = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  logic [lpd_pkg::DATA_W-1:0]  data_byte,
   input  logic [lpd_pkg::LEN_W-1:0]   max_body_length,
   output logic                        result_valid,
   output lpd_pkg::lpd_result_type     result
);
   import lpd_pkg::*;

   localparam logic [HCOUNT_W:0] LEN_N = (HCOUNT_W+1)'(LENGTH_BYTES);
   localparam logic [HCOUNT_W:0] ID_N  = (HCOUNT_W+1)'(ID_BYTES);

   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [HCOUNT_W-1:0] hcount_ff, hcount_in;
   logic [LEN_W-1:0]    len_acc_ff, len_acc_in;
   logic [ID_W-1:0]     id_acc_ff, id_acc_in;
   logic [LEN_W-1:0]    remain_ff, remain_in;
   logic                ovf_ff, ovf_in;

   logic [HCOUNT_W-1:0] hcount_next;
   logic [LEN_W-1:0]    len_base;
   logic [LEN_W-1:0]    len_new;
   logic                ovf_new;
   logic [LEN_W-1:0]    remain_dec;

   always_comb begin
      phase_in     = phase_ff;
      hcount_in    = hcount_ff;
      len_acc_in   = len_acc_ff;
      id_acc_in    = id_acc_ff;
      remain_in    = remain_ff;
      ovf_in       = ovf_ff;
      result_valid = 1'b0;
      result       = '0;

      hcount_next = hcount_ff + HCOUNT_W'(1);
      len_base    = (hcount_ff == '0) ? '0 : len_acc_ff;
      ovf_new     = ((hcount_ff == '0) ? 1'b0 : ovf_ff) | (len_base[LEN_W-1 -: DATA_W] != '0);
      len_new     = {len_base[LEN_W-DATA_W-1:0], data_byte};
      remain_dec  = (remain_ff != '0) ? remain_ff - LEN_W'(1) : remain_ff;

      case (phase_ff)
         PH_LEN: begin
            len_acc_in = len_new;
            ovf_in     = ovf_new;
            hcount_in  = hcount_next;
            if ({1'b0, hcount_next} >= LEN_N || hcount_next == '0) begin
               hcount_in = '0;
               if (ovf_new || len_new > max_body_length) begin
                  phase_in           = PH_CLOSED;
                  result_valid       = 1'b1;
                  result.kind        = KIND_ERROR;
                  result.body_length = ovf_new ? '1 : len_new;
               end else begin
                  phase_in  = PH_ID;
                  id_acc_in = '0;
               end
            end
         end
         PH_ID: begin
            id_acc_in = {id_acc_ff[ID_W-DATA_W-1:0], data_byte};
            hcount_in = hcount_next;
            if ({1'b0, hcount_next} >= ID_N || hcount_next == '0) begin
               hcount_in = '0;
               if (len_acc_ff == '0) begin
                  phase_in            = PH_LEN;
                  result_valid        = 1'b1;
                  result.kind         = KIND_EMPTY;
                  result.message_id   = id_acc_in;
                  result.last_of_body = 1'b1;
               end else begin
                  phase_in  = PH_BODY;
                  remain_in = len_acc_ff;
               end
            end
         end
         PH_BODY: begin
            result_valid         = 1'b1;
            result.kind          = KIND_BODY;
            result.message_id    = id_acc_ff;
            result.body_length   = len_acc_ff;
            result.body_byte     = data_byte;
            result.first_of_body = (remain_ff == len_acc_ff);
            result.last_of_body  = (remain_ff <= LEN_W'(1));
            remain_in            = remain_dec;
            if (remain_dec == '0) begin
               phase_in  = PH_LEN;
               hcount_in = '0;
            end
         end
         default: begin
            phase_in = PH_CLOSED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LEN;
         hcount_ff  <= '0;
         len_acc_ff <= '0;
         id_acc_ff  <= '0;
         remain_ff  <= '0;
         ovf_ff     <= 1'b0;
      end else if (take) begin
         phase_ff   <= phase_in;
         hcount_ff  <= hcount_in;
         len_acc_ff <= len_acc_in;
         id_acc_ff  <= id_acc_in;
         remain_ff  <= remain_in;
         ovf_ff     <= ovf_in;
      end
   end

endmodule

FILE: tb/sv/tb_length_prefixed_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_deframer
// Self-checking testbench for the cut-through length-prefixed deframer.
// A local parser mirrors the header, id and body phases. It predicts every
// body byte, empty-body and oversize result, which are then compared field
// by field with the result channel. Runs directed frames, limit extremes,
// random frames under random idling, a long receiver hold-off, and finally
// the oversize close, which must swallow every later byte.
// ----------------------------------------------------------------------------
module tb_length_prefixed_deframer;
   import lpd_pkg::*;

   localparam int unsigned LENGTH_BYTES   = 4;
   localparam int unsigned ID_BYTES       = 2;
   localparam int          RESULT_LATENCY = 2;
   localparam int          CYCLE_LIMIT    = 2000000;
   localparam int          RANDOM_ITEMS   = 1450;
   localparam int          LONG_HOLD      = 300;

   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              req_valid     = 1'b0;
   logic              req_stall;
   logic [DATA_W-1:0] req_data_byte = '0;
   logic              rsp_valid;
   logic              rsp_stall     = 1'b0;
   logic [KIND_W-1:0] rsp_result_kind;
   logic [ID_W-1:0]   rsp_message_id;
   logic [LEN_W-1:0]  rsp_body_length;
   logic [DATA_W-1:0] rsp_body_byte;
   logic              rsp_first_of_body;
   logic              rsp_last_of_body;
   logic              csr_wr_en     = 1'b0;
   logic [LEN_W-1:0]  csr_wr_data   = '0;

   // local copy of the parser
   logic [PHASE_W-1:0]  parse_phase;
   logic [HCOUNT_W-1:0] hdr_count;
   logic [LEN_W-1:0]    len_acc;
   logic [LEN_W-1:0]    bytes_left;
   logic [LEN_W-1:0]    max_len;
   logic [ID_W-1:0]     id_acc;
   logic                len_ovf;

   lpd_result_type frame_results_due[$];

   bit idle_enable  = 1'b1;
   bit hold_toggle  = 1'b0;
   bit hold_seen    = 1'b0;
   int stall_left   = 0;
   int stall_pick   = 0;
   int fail_count   = 0;
   int items_sent   = 0;
   int results_seen = 0;
   int frames_sent  = 0;
   int limit_writes = 0;
   int cycle_count  = 0;

   length_prefixed_deframer #(
      .LENGTH_BYTES(LENGTH_BYTES),
      .ID_BYTES    (ID_BYTES)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_message_id   (rsp_message_id),
      .rsp_body_length  (rsp_body_length),
      .rsp_body_byte    (rsp_body_byte),
      .rsp_first_of_body(rsp_first_of_body),
      .rsp_last_of_body (rsp_last_of_body),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_enable || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [LEN_W-1:0] pick_length(input logic [LEN_W-1:0] limit);
      int r;
      logic [LEN_W-1:0] top;
      r = $urandom_range(0, 99);
      if (r < 70) top = 12;
      else if (r < 95) top = 48;
      else top = 300;
      if (limit < top) top = limit;
      if (r >= 97) return top;
      return $urandom_range(0, top);
   endfunction

   // advances the local parser by one byte, returns 1 when a result is due
   function automatic bit deframe_byte(input logic [DATA_W-1:0] b,
                                       output lpd_result_type r);
      r = '0;
      case (parse_phase)
         PH_LEN: begin
            if (hdr_count == 0) begin
               len_acc = '0;
               len_ovf = 1'b0;
            end
            if (len_acc[31:24] != 0) len_ovf = 1'b1;
            len_acc   = {len_acc[23:0], b};
            hdr_count = hdr_count + 1'b1;
            if (hdr_count >= LENGTH_BYTES || hdr_count == 0) begin
               hdr_count = '0;
               if (len_ovf || len_acc > max_len) begin
                  parse_phase   = PH_CLOSED;
                  r.kind        = KIND_ERROR;
                  r.body_length = len_ovf ? '1 : len_acc;
                  return 1'b1;
               end
               parse_phase = PH_ID;
               id_acc      = '0;
            end
            return 1'b0;
         end
         PH_ID: begin
            id_acc    = {id_acc[7:0], b};
            hdr_count = hdr_count + 1'b1;
            if (hdr_count >= ID_BYTES || hdr_count == 0) begin
               hdr_count = '0;
               if (len_acc == 0) begin
                  parse_phase    = PH_LEN;
                  r.kind         = KIND_EMPTY;
                  r.message_id   = id_acc;
                  r.last_of_body = 1'b1;
                  return 1'b1;
               end
               parse_phase = PH_BODY;
               bytes_left  = len_acc;
            end
            return 1'b0;
         end
         PH_BODY: begin
            r.kind          = KIND_BODY;
            r.message_id    = id_acc;
            r.body_length   = len_acc;
            r.body_byte     = b;
            r.first_of_body = (bytes_left == len_acc);
            r.last_of_body  = (bytes_left <= 1);
            if (bytes_left != 0) bytes_left = bytes_left - 1'b1;
            if (bytes_left == 0) begin
               parse_phase = PH_LEN;
               hdr_count   = '0;
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want_v,
                                       input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0h, actual %0h", name, want_v, got_v);
         fail_count++;
      end
   endfunction

   function automatic void check_result();
      lpd_result_type got;
      lpd_result_type want;
      got = {rsp_result_kind, rsp_message_id, rsp_body_length, rsp_body_byte,
             rsp_first_of_body, rsp_last_of_body};
      results_seen++;
      if (frame_results_due.size() == 0) begin
         $error("result with no item waiting: kind %0h id %0h", got.kind, got.message_id);
         fail_count++;
         return;
      end
      want = frame_results_due[0];
      frame_results_due.delete(0);
      check_field("result_kind", 32'(want.kind), 32'(got.kind));
      check_field("message_id", 32'(want.message_id), 32'(got.message_id));
      check_field("body_length", want.body_length, got.body_length);
      check_field("body_byte", 32'(want.body_byte), 32'(got.body_byte));
      check_field("first_of_body", 32'(want.first_of_body), 32'(got.first_of_body));
      check_field("last_of_body", 32'(want.last_of_body), 32'(got.last_of_body));
   endfunction

   // result side: check accepted items, then pick the next stall value
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) check_result();
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         stall_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_pick = pick_gap();
         if (stall_pick > 0) begin
            stall_left = stall_pick - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_byte(input logic [DATA_W-1:0] b);
      lpd_result_type r;
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (deframe_byte(b, r)) frame_results_due.push_back(r);
      items_sent++;
   endtask

   task automatic send_header(input logic [LEN_W-1:0] len, input logic [ID_W-1:0] id);
      for (int i = LENGTH_BYTES - 1; i >= 0; i--) send_byte(len[8*i +: 8]);
      for (int i = ID_BYTES - 1; i >= 0; i--) send_byte(id[8*i +: 8]);
      frames_sent++;
   endtask

   task automatic send_frame(input logic [LEN_W-1:0] len, input logic [ID_W-1:0] id);
      send_header(len, id);
      repeat (len) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (frame_results_due.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_max_length(input logic [LEN_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      max_len = v;
      limit_writes++;
   endtask

   task automatic test_directed_frames();
      // empty body with all-ones id, then single and short bodies
      send_header(0, 16'hFFFF);
      send_header(1, 16'h0000);
      send_byte(8'hFF);
      send_header(3, 16'hA55A);
      send_byte(8'h00);
      send_byte(8'h80);
      send_byte(8'h7F);
      wait_drained();
   endtask

   task automatic test_limit_extremes();
      write_max_length('0);
      send_header(0, 16'($urandom_range(0, 65535)));
      send_header(0, 16'($urandom_range(0, 65535)));
      wait_drained();
      write_max_length('1);
      send_frame(5, 16'($urandom_range(0, 65535)));
      wait_drained();
      // length exactly at the limit is still accepted
      write_max_length(7);
      send_frame(7, 16'($urandom_range(0, 65535)));
      wait_drained();
   endtask

   task automatic test_random_frames();
      int stop_at;
      logic [LEN_W-1:0] lim;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         case ($urandom_range(0, 3))
            0: lim = '1;
            1: lim = $urandom_range(0, 16);
            2: lim = $urandom_range(17, 1000);
            default: lim = $urandom;
         endcase
         write_max_length(lim);
         idle_enable = ($urandom_range(0, 4) != 0);
         repeat ($urandom_range(3, 10))
            send_frame(pick_length(lim), 16'($urandom_range(0, 65535)));
         wait_drained();
      end
      idle_enable = 1'b1;
   endtask

   task automatic test_fill_and_stall();
      idle_enable = 1'b0;
      hold_toggle <= ~hold_toggle;
      send_frame(120, 16'($urandom_range(0, 65535)));
      wait_drained();
      idle_enable = 1'b1;
   endtask

   task automatic test_oversize_close();
      // error at the last length byte, then the stream stays closed
      write_max_length(32'hFFFF_FFFE);
      send_header(32'hFFFF_FFFF, 16'($urandom_range(0, 65535)));
      repeat (40) send_byte(8'($urandom_range(0, 255)));
      wait_drained();
   endtask

   initial begin
      parse_phase = PH_LEN;
      hdr_count   = '0;
      len_acc     = '0;
      id_acc      = '0;
      bytes_left  = '0;
      len_ovf     = 1'b0;
      max_len     = MAX_LEN_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_limit_extremes();
      test_random_frames();
      test_fill_and_stall();
      test_oversize_close();
      wait_drained();

      $display("run: %0d bytes in %0d frames, %0d results checked, %0d limit writes",
               items_sent, frames_sent, results_seen, limit_writes);
      $display("run: empty and body frames, limit extremes, hold-off and oversize close");
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
